@@ rtl/core/sm3_pkg.sv @@
package sm3_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned CountW = 61;
    localparam int unsigned Rounds = 64;

    typedef logic [WordW-1:0] t_word;

    localparam t_word TjLow = 32'h79CC4519;
    localparam t_word TjHigh = 32'h7A879D8A;
    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LastLenPos = 6'd55;

    function automatic t_word iv_word(input logic [2:0] k);
        t_word v;
        case (k)
            3'd0: v = 32'h7380166F;
            3'd1: v = 32'h4914B2B9;
            3'd2: v = 32'h172442D7;
            3'd3: v = 32'hDA8A0600;
            3'd4: v = 32'hA96F30BC;
            3'd5: v = 32'h163138AA;
            3'd6: v = 32'hE38DEE4D;
            default: v = 32'hB0FB0E4E;
        endcase
        return v;
    endfunction

    function automatic t_word rol(input t_word x, input logic [4:0] n);
        logic [2*WordW-1:0] d;
        d = {x, x} << n;
        return d[2*WordW-1:WordW];
    endfunction

    function automatic t_word perm0(input t_word x);
        return x ^ rol(x, 5'd9) ^ rol(x, 5'd17);
    endfunction

    function automatic t_word perm1(input t_word x);
        return x ^ rol(x, 5'd15) ^ rol(x, 5'd23);
    endfunction

    // controller to datapath
    typedef struct packed {
        logic       load_byte;  // merge byte at pos
        logic       pad;        // write pad byte at pos, zero words above
        logic       clear_blk;  // zero all block words
        logic       put_len;    // write bit length to words 14 and 15
        logic       start;      // load round regs, begin 64 rounds
        logic       reset_msg;  // chain back to IV
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_sts;

endpackage

@@ rtl/core/sm3_if.sv @@
interface sm3_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       last_byte;
    modport source(output valid, msg_byte, has_byte, last_byte, input ready);
    modport sink(input valid, msg_byte, has_byte, last_byte, output ready);
endinterface

interface sm3_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_done;
    logic        length_error;
    modport source(output valid, digest_word, word_index, digest_done, length_error,
                   input ready);
    modport sink(input valid, digest_word, word_index, digest_done, length_error,
                 output ready);
endinterface

@@ rtl/core/sm3_datapath.sv @@
module sm3_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sm3_pkg::t_cmd i_cmd,
    input  logic [7:0]    i_byte,
    input  logic [5:0]    i_pos,
    input  logic [63:0]   i_bits,
    input  logic [2:0]    i_rd_idx,
    output sm3_pkg::t_sts o_sts,
    output sm3_pkg::t_word o_chain
);
    import sm3_pkg::*;

    t_word r_blk [16];
    t_word r_w [16];
    t_word r_chain [8];
    t_word r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [5:0] r_rnd;
    logic       r_busy;

    logic [3:0] wi;
    logic [1:0] bi;
    assign wi = i_pos[5:2];
    assign bi = i_pos[1:0];

    t_word tj, a12, ss1, ss2, ff, gg, tt1, tt2, w4, wnew;
    logic hi;
    always_comb begin
        hi = (r_rnd >= 6'd16);
        tj = rol(hi ? TjHigh : TjLow, r_rnd[4:0]);
        a12 = rol(r_a, 5'd12);
        ss1 = rol(a12 + r_e + tj, 5'd7);
        ss2 = ss1 ^ a12;
        ff = hi ? ((r_a & r_b) | (r_a & r_c) | (r_b & r_c)) : (r_a ^ r_b ^ r_c);
        gg = hi ? ((r_e & r_f) | (~r_e & r_g)) : (r_e ^ r_f ^ r_g);
        w4 = r_w[4];
        tt1 = ff + r_d + ss2 + (r_w[0] ^ w4);
        tt2 = gg + r_h + ss1 + r_w[0];
        // expansion word j+16 from window w[j..j+15]
        wnew = perm1(r_w[0] ^ r_w[7] ^ rol(r_w[13], 5'd15)) ^ rol(r_w[3], 5'd7) ^ r_w[10];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            case (bi)
                2'd0: r_blk[wi] <= {i_byte, 24'd0};
                2'd1: r_blk[wi][23:16] <= i_byte;
                2'd2: r_blk[wi][15:8] <= i_byte;
                default: r_blk[wi][7:0] <= i_byte;
            endcase
        end
        if (i_cmd.pad) begin
            case (bi)
                2'd0: r_blk[wi] <= {PadByte, 24'd0};
                2'd1: r_blk[wi][23:0] <= {PadByte, 16'd0};
                2'd2: r_blk[wi][15:0] <= {PadByte, 8'd0};
                default: r_blk[wi][7:0] <= PadByte;
            endcase
            for (int k = 0; k < 16; k++)
                if (4'(k) > wi) r_blk[k] <= '0;
        end
        if (i_cmd.clear_blk)
            for (int k = 0; k < 16; k++) r_blk[k] <= '0;
        if (i_cmd.put_len) begin
            r_blk[14] <= i_bits[63:32];
            r_blk[15] <= i_bits[31:0];
        end
        if (i_cmd.start) begin
            for (int k = 0; k < 15; k++) r_w[k] <= r_blk[k];
            // the block's final byte arrives in the same cycle as start
            r_w[15] <= i_cmd.load_byte ? {r_blk[15][31:8], i_byte} : r_blk[15];
            {r_a, r_b, r_c, r_d} <= {r_chain[0], r_chain[1], r_chain[2], r_chain[3]};
            {r_e, r_f, r_g, r_h} <= {r_chain[4], r_chain[5], r_chain[6], r_chain[7]};
        end else if (r_busy) begin
            for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
            r_w[15] <= wnew;
            r_d <= r_c; r_c <= rol(r_b, 5'd9); r_b <= r_a; r_a <= tt1;
            r_h <= r_g; r_g <= rol(r_f, 5'd19); r_f <= r_e; r_e <= perm0(tt2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rnd <= '0;
            for (int k = 0; k < 8; k++) r_chain[k] <= iv_word(3'(k));
        end else begin
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_rnd <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'(Rounds - 1)) begin
                    r_busy <= 1'b0;
                    r_chain[0] <= r_chain[0] ^ tt1;
                    r_chain[1] <= r_chain[1] ^ r_a;
                    r_chain[2] <= r_chain[2] ^ rol(r_b, 5'd9);
                    r_chain[3] <= r_chain[3] ^ r_c;
                    r_chain[4] <= r_chain[4] ^ perm0(tt2);
                    r_chain[5] <= r_chain[5] ^ r_e;
                    r_chain[6] <= r_chain[6] ^ rol(r_f, 5'd19);
                    r_chain[7] <= r_chain[7] ^ r_g;
                end
            end
            if (i_cmd.reset_msg)
                for (int k = 0; k < 8; k++) r_chain[k] <= iv_word(3'(k));
        end
    end

    assign o_sts.busy = r_busy;
    assign o_chain = r_chain[i_rd_idx];
endmodule

@@ rtl/core/sm3_ctrl.sv @@
module sm3_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_has,
    input  logic          i_last,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [2:0]    o_idx,
    output logic          o_err,
    output sm3_pkg::t_cmd o_cmd,
    output logic [7:0]    o_byte,
    output logic [5:0]    o_pos,
    output logic [63:0]   o_bits,
    input  sm3_pkg::t_sts i_sts
);
    import sm3_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD   = 7'b0000010,
        S_WAIT1 = 7'b0000100,
        S_CLR   = 7'b0001000,
        S_LEN   = 7'b0010000,
        S_WAIT2 = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [CountW-1:0] r_count;
    logic r_ovf;
    logic [2:0] r_idx;
    logic r_fired;   // start issued for the wait state
    logic accept, absorb;

    assign o_ready = (r_state == S_IDLE) && !i_sts.busy && !r_fired;
    assign accept = i_valid && o_ready;
    assign absorb = accept && i_has && (r_count != {CountW{1'b1}});
    assign o_pos = r_count[5:0];
    assign o_byte = i_byte;
    assign o_bits = {r_count, 3'b000};
    assign o_out_valid = (r_state == S_OUT);
    assign o_idx = r_idx;
    assign o_err = r_ovf;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_byte = absorb;
                o_cmd.start = absorb && (r_count[5:0] == 6'd63);
                if (accept && i_last) n_state = S_PAD;
            end
            S_PAD: begin
                o_cmd.pad = 1'b1;
                n_state = (r_count[5:0] > LastLenPos) ? S_WAIT1 : S_LEN;
            end
            S_WAIT1: begin
                o_cmd.start = !r_fired;
                if (r_fired && !i_sts.busy) n_state = S_CLR;
            end
            S_CLR: begin
                o_cmd.clear_blk = 1'b1;
                n_state = S_LEN;
            end
            S_LEN: begin
                o_cmd.put_len = !i_sts.busy;
                if (!i_sts.busy) n_state = S_WAIT2;
            end
            S_WAIT2: begin
                o_cmd.start = !r_fired;
                if (r_fired && !i_sts.busy) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready && r_idx == 3'd7) begin
                    o_cmd.reset_msg = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf <= 1'b0;
            r_idx <= '0;
            r_fired <= 1'b0;
        end else begin
            r_state <= n_state;
            if (absorb) r_count <= r_count + 1'b1;
            if (accept && i_has && !absorb) r_ovf <= 1'b1;
            // hold in a wait state until it exits; elsewhere drop once busy is seen
            if (o_cmd.start)
                r_fired <= 1'b1;
            else if ((r_state == S_WAIT1 || r_state == S_WAIT2) ? (n_state != r_state)
                                                                : i_sts.busy)
                r_fired <= 1'b0;
            if (r_state == S_OUT && i_out_ready) begin
                r_idx <= r_idx + 3'd1;
                if (r_idx == 3'd7) begin
                    r_count <= '0;
                    r_ovf <= 1'b0;
                end
            end
        end
    end
endmodule

@@ rtl/core/sm3_hash_engine.sv @@
// SM3 byte-stream hash engine.
// Throughput: one byte per cycle while ready; a full block then goes through compression,
// during which input stalls (one shared round unit, one round per cycle).
// Last transaction: pad, an extra block if the length does not fit, length words, compression,
// then 8 digest words; input stalls until the last word is taken.
// Reset (synchronous, active low) loads the IV and clears count and error flag.
module sm3_hash_engine (
    input logic i_clk,
    input logic i_rst_n,
    sm3_in_if.sink    i_in,
    sm3_out_if.source o_out
);
    import sm3_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic [7:0] byte_q;
    logic [5:0] pos;
    logic [63:0] bits;
    logic [2:0] idx;

    sm3_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in.valid), .o_ready(i_in.ready),
        .i_byte(i_in.msg_byte), .i_has(i_in.has_byte), .i_last(i_in.last_byte),
        .i_out_ready(o_out.ready), .o_out_valid(o_out.valid),
        .o_idx(idx), .o_err(o_out.length_error),
        .o_cmd(cmd), .o_byte(byte_q), .o_pos(pos), .o_bits(bits), .i_sts(sts)
    );

    sm3_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_byte(byte_q),
        .i_pos(pos), .i_bits(bits), .i_rd_idx(idx), .o_sts(sts),
        .o_chain(o_out.digest_word)
    );

    assign o_out.word_index = idx;
    assign o_out.digest_done = (idx == 3'd7);
endmodule
